/* rtl/ahd_pkg.sv */
// ----------------------------------------------------------------------------
// ahd_pkg: shared types and constants for the accelerometer hit detector
// Item codes, register indexes, stream widths and reset values.
// ----------------------------------------------------------------------------
package ahd_pkg;

    // Item kind carried on s_tuser
    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS  = 3'd4;

    localparam logic [15:0] THRESHOLD_X_RST = 16'd12000;
    localparam logic [15:0] THRESHOLD_Y_RST = 16'd18000;
    localparam logic [15:0] THRESHOLD_Z_RST = 16'd10;
    localparam logic [15:0] Z_OFFSET_RST    = 16'd16300;
    localparam logic [15:0] HOLDOFF_MS_RST  = 16'd100;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;
    localparam int NUM_AXES  = 3;

    // Divide by 1000 as multiply by ceil(2^26 / 1000), exact for 16-bit dividends
    localparam logic [16:0] ZDIV_RECIP = 17'd67109;
    localparam int          ZDIV_SHIFT = 26;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

endpackage

/* rtl/accel_hit_detector.sv */
// ----------------------------------------------------------------------------
// accel_hit_detector: three-axis accelerometer hit detector
// Per-axis crossing detection with millisecond holdoff; one hit word per sample.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload                                 | Transfers
//  ---------+-----------+-----------------------------------------+------------------
//  s_       | in        | tuser: opcode; tdata: x, y, z (16 each) | tick or sample
//  m_       | out       | tdata: hit_x, hit_y, hit_z, zero pad    | one per sample
//  cfg_     | in        | index 0..4, 16-bit write data           | write on cfg_we
//
//  Three register stages: input register, z scaling register, result register.
//  Items pass them in order up to m_tvalid; one item per cycle unless m_ stalls.
//  The z path (offset subtract, one 16x17 multiply) fills the middle stage; the
//  per-axis compare against stored magnitudes and counters fills the last one.
//  Tick items leave no result. A stalled m_ side holds the result and the stages
//  behind it fill up before s_tready drops. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module accel_hit_detector (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ahd_pkg::S_TDATA_W-1:0]  s_tdata,   // x_sample, y_sample, z_sample
    input  logic                           s_tuser,   // opcode
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ahd_pkg::M_TDATA_W-1:0]  m_tdata,   // hit_x, hit_y, hit_z, 5 zero bits
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [ahd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ahd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ahd_pkg::*;

    // Magnitude of a signed word, saturated to 15 bits
    function automatic logic [14:0] mag_sat(input logic [15:0] v);
        logic [15:0] m;
        begin
            m = v[15] ? 16'(~v + 16'd1) : v;
            mag_sat = m[15] ? 15'h7FFF : m[14:0];
        end
    endfunction

    // |prev - cur| where prev is a stored magnitude
    function automatic logic [16:0] abs_diff(input logic [14:0] prev,
                                             input logic [15:0] cur);
        logic signed [17:0] d;
        begin
            d = $signed({3'b000, prev}) - $signed({{2{cur[15]}}, cur});
            abs_diff = d[17] ? 17'(-d) : d[16:0];
        end
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [15:0] thr_reg [NUM_AXES];
    logic [15:0] z_offset_reg;
    logic [15:0] holdoff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg[0]   <= THRESHOLD_X_RST;
            thr_reg[1]   <= THRESHOLD_Y_RST;
            thr_reg[2]   <= THRESHOLD_Z_RST;
            z_offset_reg <= Z_OFFSET_RST;
            holdoff_reg  <= HOLDOFF_MS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD_X: thr_reg[0]   <= cfg_wdata;
                REG_THRESHOLD_Y: thr_reg[1]   <= cfg_wdata;
                REG_THRESHOLD_Z: thr_reg[2]   <= cfg_wdata;
                REG_Z_OFFSET:    z_offset_reg <= cfg_wdata;
                REG_HOLDOFF_MS:  holdoff_reg  <= cfg_wdata;
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control: a stage advances when the one ahead is free
    // ------------------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, m_valid_reg;
    op_t  a_op_reg, b_op_reg;
    logic out_free, b_go, b_free, a_go, a_free, s_go;

    assign out_free = !m_valid_reg || m_tready;
    // Ticks never touch the output register, so they drain regardless of m_ side
    assign b_go     = b_valid_reg && (b_op_reg == OP_TICK || out_free);
    assign b_free   = !b_valid_reg || b_go;
    assign a_go     = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || a_go;
    assign s_tready = a_free;
    assign s_go     = s_tvalid && a_free;

    // ------------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------------
    logic [15:0] a_x_reg, a_y_reg, a_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_free) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_go) begin
            a_op_reg <= op_t'(s_tuser);
            a_x_reg  <= s_tdata[15:0];
            a_y_reg  <= s_tdata[31:16];
            a_z_reg  <= s_tdata[47:32];
        end
    end

    // z scaling: (z - offset) / 1000, truncated toward zero
    logic signed [16:0] z_diff;
    logic               z_neg;
    logic [16:0]        z_neg_diff;
    logic [15:0]        z_mag;
    logic [32:0]        z_prod;
    logic [6:0]         z_quot_mag;
    logic [7:0]         z_quot;

    always_comb begin
        z_diff     = $signed({1'b0, a_z_reg}) - $signed({1'b0, z_offset_reg});
        z_neg      = z_diff[16];
        z_neg_diff = 17'(-z_diff);
        z_mag      = z_neg ? z_neg_diff[15:0] : z_diff[15:0];
        z_prod     = 33'(z_mag) * 33'(ZDIV_RECIP);
        z_quot_mag = z_prod[ZDIV_SHIFT +: 7];
        z_quot     = z_neg ? 8'(-{1'b0, z_quot_mag}) : {1'b0, z_quot_mag};
    end

    // ------------------------------------------------------------------------
    // Stage B: scaled sample register
    // ------------------------------------------------------------------------
    logic [15:0] b_x_reg, b_y_reg;
    logic [7:0]  b_zq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go) begin
            b_op_reg <= a_op_reg;
            b_x_reg  <= a_x_reg;
            b_y_reg  <= a_y_reg;
            b_zq_reg <= z_quot;
        end
    end

    // ------------------------------------------------------------------------
    // Judge: all axes see the previous magnitudes before any update
    // ------------------------------------------------------------------------
    logic [14:0] prev_mag_reg [NUM_AXES];
    logic [14:0] prev_mag_next [NUM_AXES];
    logic [15:0] cnt_reg  [NUM_AXES];
    logic [15:0] cnt_next [NUM_AXES];
    logic [15:0] cur      [NUM_AXES];
    logic [NUM_AXES-1:0] crossing, hit;

    always_comb begin
        cur[0] = b_x_reg;
        cur[1] = b_y_reg;
        cur[2] = {{8{b_zq_reg[7]}}, b_zq_reg};
        for (int k = 0; k < NUM_AXES; k++) begin
            crossing[k] = (prev_mag_reg[k] != '0) &&
                          (abs_diff(prev_mag_reg[k], cur[k]) > {1'b0, thr_reg[k]});
            hit[k]      = crossing[k] && (cnt_reg[k] > holdoff_reg);

            prev_mag_next[k] = prev_mag_reg[k];
            cnt_next[k]      = cnt_reg[k];
            if (b_go) begin
                if (b_op_reg == OP_TICK) begin
                    // advance, saturate at full scale
                    if (cnt_reg[k] != CNT_MAX) begin
                        cnt_next[k] = cnt_reg[k] + 16'd1;
                    end
                end else begin
                    prev_mag_next[k] = mag_sat(cur[k]);
                    if (crossing[k]) begin
                        cnt_next[k] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                prev_mag_reg[k] <= '0;
                cnt_reg[k]      <= CNT_MAX;
            end
        end else begin
            for (int k = 0; k < NUM_AXES; k++) begin
                prev_mag_reg[k] <= prev_mag_next[k];
                cnt_reg[k]      <= cnt_next[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result register: load on a sample, clear on transfer
    // ------------------------------------------------------------------------
    logic [NUM_AXES-1:0] m_hit_reg;
    logic                m_valid_next;
    logic                m_load;

    assign m_load = b_go && (b_op_reg == OP_SAMPLE);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_hit_reg <= hit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - NUM_AXES)'(0), m_hit_reg};

endmodule

/* rtl/ahd_checker.sv */
// ----------------------------------------------------------------------------
// ahd_checker: port-level checks for the accelerometer hit detector
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ahd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ahd_pkg::M_TDATA_W-1:0] m_tdata
);
    import ahd_pkg::*;

    // A stalled result holds its hit bits
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Reset empties the input stage, so the block is ready at once
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("not ready right after reset");

    // Only three hit bits are defined; the padding stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:NUM_AXES] == '0)
        else $error("nonzero padding in result");

endmodule

bind accel_hit_detector ahd_checker u_ahd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/accel_hit_detector_checker.sv */
// ----------------------------------------------------------------------------
// accel_hit_detector_checker: hit word predictor and scoreboard
// Watches the sample stream, the hit stream and register writes. It predicts
// each hit word and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module accel_hit_detector_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ahd_pkg::S_TDATA_W-1:0]  s_tdata,   // x_sample, y_sample, z_sample
    input  logic                           s_tuser,   // opcode
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ahd_pkg::M_TDATA_W-1:0]  m_tdata,   // hit_x, hit_y, hit_z, 5 zero bits
    input  logic                           cfg_we,
    input  logic [ahd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ahd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             words_checked,
    output int                             hits_seen
);
    import ahd_pkg::*;

    localparam int AXIS_X  = 0;
    localparam int AXIS_Y  = 1;
    localparam int AXIS_Z  = 2;
    localparam int Z_SCALE = 1000;

    // hit_x sits in bit 0
    typedef struct packed {
        logic hit_z;
        logic hit_y;
        logic hit_x;
    } hit_word_t;

    logic [15:0] thr_x, thr_y, thr_z, z_off, holdoff;
    logic [15:0] last_mag [NUM_AXES];
    logic [15:0] ms_since [NUM_AXES];
    hit_word_t   hits_due [$];

    function automatic logic [15:0] clip_mag(int v);
        int a;
        a = (v < 0) ? -v : v;
        return (a > 32767) ? 16'h7FFF : a[15:0];
    endfunction

    // Crossing test for one axis; a crossing restarts that axis counter
    function automatic logic judge_axis(int axis, int cur, logic [15:0] thr);
        int   diff;
        logic fired;
        fired = 1'b0;
        if (last_mag[axis] != '0) begin
            diff = int'(last_mag[axis]) - cur;
            if (diff < 0)
                diff = -diff;
            if (diff > int'(thr)) begin
                fired          = (ms_since[axis] > holdoff);
                ms_since[axis] = '0;
            end
        end
        return fired;
    endfunction

    // All axes are judged against the old magnitudes, then those are replaced
    function automatic hit_word_t predict_hits(logic [15:0] xw, logic [15:0] yw,
                                               logic [15:0] zw);
        int        axis_val [NUM_AXES];
        hit_word_t h;
        axis_val[AXIS_X] = $signed(xw);
        axis_val[AXIS_Y] = $signed(yw);
        axis_val[AXIS_Z] = (int'(zw) - int'(z_off)) / Z_SCALE;
        h.hit_x = judge_axis(AXIS_X, axis_val[AXIS_X], thr_x);
        h.hit_y = judge_axis(AXIS_Y, axis_val[AXIS_Y], thr_y);
        h.hit_z = judge_axis(AXIS_Z, axis_val[AXIS_Z], thr_z);
        for (int a = 0; a < NUM_AXES; a++)
            last_mag[a] = clip_mag(axis_val[a]);
        return h;
    endfunction

    task automatic check_bit(string field, logic want, logic got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        hit_word_t want;
        hit_word_t got;
        if (!aresetn) begin
            thr_x   = THRESHOLD_X_RST;
            thr_y   = THRESHOLD_Y_RST;
            thr_z   = THRESHOLD_Z_RST;
            z_off   = Z_OFFSET_RST;
            holdoff = HOLDOFF_MS_RST;
            for (int a = 0; a < NUM_AXES; a++) begin
                last_mag[a] = '0;
                ms_since[a] = CNT_MAX;
            end
            hits_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_THRESHOLD_X: thr_x   = cfg_wdata;
                    REG_THRESHOLD_Y: thr_y   = cfg_wdata;
                    REG_THRESHOLD_Z: thr_z   = cfg_wdata;
                    REG_Z_OFFSET:    z_off   = cfg_wdata;
                    REG_HOLDOFF_MS:  holdoff = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = hit_word_t'(m_tdata[2:0]);
                if (hits_due.size() == 0) begin
                    $error("hit word %b arrived with nothing outstanding", m_tdata);
                    fail_count++;
                end else begin
                    want = hits_due.pop_front();
                    check_bit("hit_x", want.hit_x, got.hit_x);
                    check_bit("hit_y", want.hit_y, got.hit_y);
                    check_bit("hit_z", want.hit_z, got.hit_z);
                    if (m_tdata[M_TDATA_W-1:3] !== '0) begin
                        $error("pad mismatch: expected 0, actual %0d",
                               m_tdata[M_TDATA_W-1:3]);
                        fail_count++;
                    end
                    words_checked++;
                    hits_seen += $countones(got);
                end
            end
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser) == OP_TICK) begin
                    for (int a = 0; a < NUM_AXES; a++)
                        if (ms_since[a] != CNT_MAX)
                            ms_since[a] = ms_since[a] + 16'd1;
                end else begin
                    hits_due.push_back(predict_hits(s_tdata[15:0], s_tdata[31:16],
                                                    s_tdata[47:32]));
                end
            end
        end
        pending = hits_due.size();
    end

endmodule

/* tb/sv/accel_hit_detector_test.sv */
// ----------------------------------------------------------------------------
// accel_hit_detector_test: stimulus and verdict for the hit detector
// Directed samples and ticks on the extremes, then random traffic over several
// register settings with random gaps on both streams and one long result
// stall. The checker beside the block predicts and compares every hit word.
// ----------------------------------------------------------------------------
module accel_hit_detector_test;
    import ahd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_CYCLES  = 200;    // long result hold-off
    localparam int PHASE_ITEMS   = 125;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // x_sample, y_sample, z_sample
    logic                  s_tuser   = OP_TICK;   // opcode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // hit_x, hit_y, hit_z, 5 zero bits
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int words_checked;
    int hits_seen;

    int src_idle_pct = 0;     // chance in percent that the sender skips a cycle
    int snk_idle_pct = 0;     // chance in percent that the receiver drops tready
    int stall_req    = 0;     // bump to ask the receiver for a long hold-off
    int stall_ack    = 0;
    int stall_left   = 0;
    int cycle_count  = 0;
    int samples_sent = 0;
    int ticks_sent   = 0;
    logic [15:0] cur_zoff = Z_OFFSET_RST;

    always #5 aclk = ~aclk;

    accel_hit_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    accel_hit_detector_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .hits_seen     (hits_seen)
    );

    // Receiver: random tready, or a long hold-off when one is requested.
    // The hold-off is counted here so the sender keeps offering meanwhile.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_req != stall_ack) begin
            stall_ack  = stall_req;
            stall_left = STALL_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: give up well past the slowest legal run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d hit words outstanding",
                     cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until the transfer.
    // tvalid stays high between back-to-back items.
    task automatic send_item(input op_t op, input logic [15:0] xw,
                             input logic [15:0] yw, input logic [15:0] zw);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {zw, yw, xw};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (op == OP_SAMPLE)
            samples_sent++;
        else
            ticks_sent++;
    endtask

    // Tick with junk in the data field; the block must ignore it
    task automatic tick();
        send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic sample(input logic [15:0] xw, input logic [15:0] yw,
                          input logic [15:0] zw);
        send_item(OP_SAMPLE, xw, yw, zw);
    endtask

    // Drop tvalid, wait for every hit word, then let trailing ticks retire
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all five registers on consecutive edges; hold cfg_we across them
    task automatic apply_settings(input logic [15:0] thx, input logic [15:0] thy,
                                  input logic [15:0] thz, input logic [15:0] zoff,
                                  input logic [15:0] hold);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx = '{REG_THRESHOLD_X, REG_THRESHOLD_Y, REG_THRESHOLD_Z,
                REG_Z_OFFSET, REG_HOLDOFF_MS};
        val = '{thx, thy, thz, zoff, hold};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_we   <= 1'b0;
        cur_zoff = zoff;
    endtask

    // Axis word biased toward the extremes and zero
    function automatic logic [15:0] axis_word();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Z word; often within one scale step of the offset so the scaled value is 0
    function automatic logic [15:0] z_word();
        if ($urandom_range(4) == 0)
            return cur_zoff + 16'($urandom_range(1998)) - 16'd999;
        return axis_word();
    endfunction

    // One random phase: mostly samples, ticks in between and in short bursts
    task automatic run_phase(input logic [15:0] thx, input logic [15:0] thy,
                             input logic [15:0] thz, input logic [15:0] zoff,
                             input logic [15:0] hold, input bit squeeze);
        drain();
        apply_settings(thx, thy, thz, zoff, hold);
        if (squeeze)
            stall_req++;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(24) == 0)
                repeat ($urandom_range(2, 12)) tick();
            else if ($urandom_range(99) < 40)
                tick();
            else
                sample(axis_word(), axis_word(), z_word());
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings. Zero previous magnitudes: no crossing possible.
        src_idle_pct = 19;
        snk_idle_pct = 85;
        sample(16'h0000, 16'h0000, 16'd16300);
        // Store most negative x (kept as 32767), most positive y, top z
        sample(16'h8000, 16'h7FFF, 16'hFFFF);
        // Full-scale swings against saturated counters: all three fire
        sample(16'h8000, 16'h8000, 16'h0000);
        tick();
        // Crossings inside the holdoff: no hit, counters restart
        sample(16'h0000, 16'h7FFF, 16'd16300);
        sample(16'h7FFF, 16'hFFFF, 16'h1234);

        // Thresholds at maximum: even a full-scale change is no crossing
        drain();
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        sample(16'h8000, 16'h8000, 16'h0000);
        sample(16'h7FFF, 16'h7FFF, 16'hFFFF);
        tick();
        tick();

        // Zero thresholds and holdoff: any change crosses, one tick arms a hit
        drain();
        apply_settings(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        sample(16'h0001, 16'hFFFF, 16'h0000);
        sample(16'h0001, 16'h0001, 16'h0000);
        tick();
        sample(16'h8001, 16'h8000, 16'hFFFF);
        sample(16'h7FFF, 16'h0000, 16'd64535);

        // Holdoff one below full scale: crossings only restart the counters
        drain();
        apply_settings(16'd12000, 16'd18000, 16'd10, 16'd16300, 16'd65534);
        sample(16'h8000, 16'h7FFF, 16'h0000);
        tick();
        sample(16'h7FFF, 16'h8000, 16'hFFFF);
        sample(16'h0000, 16'h0000, 16'd16300);

        // Random part: sender lightly idle, receiver mostly stalled
        run_phase(16'd12000, 16'd18000, 16'd10, 16'd16300, 16'd3, 1'b0);
        run_phase(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'd0, 1'b0);

        // Sender mostly idle, receiver lightly stalled
        src_idle_pct = 85;
        snk_idle_pct = 19;
        run_phase(16'($urandom_range(40000)), 16'($urandom_range(40000)),
                  16'($urandom_range(20)), 16'($urandom), 16'($urandom_range(4)), 1'b0);
        run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0);

        // No idling; the first of these opens with a long result stall so
        // the pipeline fills and s_tready drops while items keep coming
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_phase(16'd20000, 16'd20000, 16'd5, 16'd32768, 16'd2, 1'b1);
        run_phase(16'd8000, 16'd30000, 16'd15, 16'($urandom), 16'd65534, 1'b0);

        drain();

        $display("covered %0d samples and %0d ticks over directed cases and six settings",
                 samples_sent, ticks_sent);
        $display("compared %0d hit words carrying %0d hits, %0d mismatches",
                 words_checked, hits_seen, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
